[hdl/matrix3x3_inverse_macros.svh]
// Assertion macros used by the checker file mi3_chk.sv.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef MATRIX3X3_INVERSE_MACROS_SVH
`define MATRIX3X3_INVERSE_MACROS_SVH

// Property checked on every rising clock edge, off while in reset.
`define MI3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form built on the macro above.
`define MI3_ASSERT_IMP(lbl, ante, cons, msg) \
  `MI3_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[hdl/mi3_pkg.sv]
// Types and constants for the 3x3 matrix inverse pipeline.
// No dependencies.
package mi3_pkg;

  localparam int unsigned NumLanes = 9;
  localparam int unsigned FracShift = 28;
  // Dividend is 2*|adj|*2^FracShift; the extra bit gives the rounding bit.
  localparam int unsigned NumShift = FracShift + 1;
  localparam int unsigned DivSteps = 34;
  localparam int unsigned InitShift = DivSteps - NumShift;
  localparam int unsigned MagW = 32;
  localparam int unsigned DenW = 48;
  localparam int unsigned QuoW = DivSteps;
  // Register stages from start to done_o.
  localparam int unsigned Latency = 4 + DivSteps + 2;

  typedef logic [MagW-1:0] mag_t;
  typedef logic [DenW-1:0] den_t;
  typedef logic [QuoW-1:0] quo_t;

  typedef struct packed {
    logic [NumLanes-1:0] neg;
    logic                singular;
  } div_tag_t;

  typedef struct packed {
    logic signed [15:0] m_row0_col0;
    logic signed [15:0] m_row0_col1;
    logic signed [15:0] m_row0_col2;
    logic signed [15:0] m_row1_col0;
    logic signed [15:0] m_row1_col1;
    logic signed [15:0] m_row1_col2;
    logic signed [15:0] m_row2_col0;
    logic signed [15:0] m_row2_col1;
    logic signed [15:0] m_row2_col2;
  } mat_t;

  typedef struct packed {
    logic signed [31:0] inv_row0_col0;
    logic signed [31:0] inv_row0_col1;
    logic signed [31:0] inv_row0_col2;
    logic signed [31:0] inv_row1_col0;
    logic signed [31:0] inv_row1_col1;
    logic signed [31:0] inv_row1_col2;
    logic signed [31:0] inv_row2_col0;
    logic signed [31:0] inv_row2_col1;
    logic signed [31:0] inv_row2_col2;
    logic               singular;
    logic               saturated;
  } res_t;

endpackage

[hdl/mi3_div.sv]
// Nine-lane pipelined restoring divider, one quotient bit per stage.
// Depends on mi3_pkg.
module mi3_div (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  input  mi3_pkg::mag_t [mi3_pkg::NumLanes-1:0]   absn_i,
  input  mi3_pkg::den_t                           absd_i,
  input  mi3_pkg::div_tag_t                       tag_i,
  output logic                                    valid_o,
  output mi3_pkg::quo_t [mi3_pkg::NumLanes-1:0]   quo_o,
  output logic [mi3_pkg::NumLanes-1:0]            ovf_o,
  output mi3_pkg::div_tag_t                       tag_o
);

  localparam int unsigned Steps = mi3_pkg::DivSteps;
  localparam int unsigned Lanes = mi3_pkg::NumLanes;
  localparam int unsigned DW = mi3_pkg::DenW;

  logic [Steps:0]                           vld_q;
  logic [Steps:0][Lanes-1:0][DW-1:0]        rem_q;
  mi3_pkg::mag_t [Steps:0][Lanes-1:0]       num_q;
  mi3_pkg::quo_t [Steps:0][Lanes-1:0]       quo_q;
  logic [Steps:0][Lanes-1:0]                ovf_q;
  mi3_pkg::den_t [Steps:0]                  den_q;
  mi3_pkg::div_tag_t [Steps:0]              tag_q;

  // Entry: top dividend bits; quotient would not fit when they reach the divisor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < Lanes; l++) begin
      rem_q[0][l] <= DW'(absn_i[l][mi3_pkg::MagW-1:mi3_pkg::InitShift]);
      ovf_q[0][l] <= DW'(absn_i[l][mi3_pkg::MagW-1:mi3_pkg::InitShift]) >= absd_i;
      quo_q[0][l] <= '0;
    end
    num_q[0] <= absn_i;
    den_q[0] <= absd_i;
    tag_q[0] <= tag_i;
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    localparam int K = Steps - 1 - i;
    logic [Lanes-1:0]         nb;
    logic [Lanes-1:0][DW:0]   trial;
    logic [Lanes-1:0][DW:0]   diff;
    logic [Lanes-1:0]         ge;

    for (genvar l = 0; l < Lanes; l++) begin : g_lane
      if (K >= mi3_pkg::NumShift) begin : g_num
        assign nb[l] = num_q[i][l][K - mi3_pkg::NumShift];
      end else begin : g_zero
        assign nb[l] = 1'b0;
      end
    end

    always_comb begin
      for (int l = 0; l < Lanes; l++) begin
        trial[l] = {rem_q[i][l], nb[l]};
        diff[l]  = trial[l] - {1'b0, den_q[i]};
        ge[l]    = trial[l] >= {1'b0, den_q[i]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      for (int l = 0; l < Lanes; l++) begin
        rem_q[i+1][l] <= ge[l] ? diff[l][DW-1:0] : trial[l][DW-1:0];
        quo_q[i+1][l] <= {quo_q[i][l][mi3_pkg::QuoW-2:0], ge[l]};
      end
      num_q[i+1] <= num_q[i];
      ovf_q[i+1] <= ovf_q[i];
      den_q[i+1] <= den_q[i];
      tag_q[i+1] <= tag_q[i];
    end
  end

  assign valid_o = vld_q[Steps];
  assign quo_o   = quo_q[Steps];
  assign ovf_o   = ovf_q[Steps];
  assign tag_o   = tag_q[Steps];

endmodule

[hdl/matrix3x3_inverse.sv]
// Top level: 3x3 matrix inverse by the adjugate, fully pipelined.
// Depends on mi3_pkg and mi3_div.
//
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------
//  input    | start / busy      | mat_i  (mi3_pkg::mat_t)
//  result   | done_o strobe     | res_o  (mi3_pkg::res_t)
//
// One matrix per cycle; busy stays low. Each result passes through 4 stages
// for products, adjugate and determinant, 35 in the one-bit-per-stage
// divider and 1 for rounding and clipping.
// Reset clears only the valid bits. done_o is a one-cycle strobe; the
// receiver takes each result in that cycle.
module matrix3x3_inverse (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  mi3_pkg::mat_t mat_i,
  output logic          done_o,
  output mi3_pkg::res_t res_o
);

  localparam int unsigned Lanes = mi3_pkg::NumLanes;
  // Cofactor i = a[PA[i]]*a[PB[i]] - a[PC[i]]*a[PD[i]]
  localparam logic [3:0] PA [Lanes] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
  localparam logic [3:0] PB [Lanes] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
  localparam logic [3:0] PC [Lanes] = '{4'd7, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd6, 4'd0, 4'd3};
  localparam logic [3:0] PD [Lanes] = '{4'd5, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd4, 4'd7, 4'd1};

  logic signed [15:0] a [Lanes];

  assign a[0] = mat_i.m_row0_col0;
  assign a[1] = mat_i.m_row0_col1;
  assign a[2] = mat_i.m_row0_col2;
  assign a[3] = mat_i.m_row1_col0;
  assign a[4] = mat_i.m_row1_col1;
  assign a[5] = mat_i.m_row1_col2;
  assign a[6] = mat_i.m_row2_col0;
  assign a[7] = mat_i.m_row2_col1;
  assign a[8] = mat_i.m_row2_col2;

  assign busy = 1'b0;

  // Stage 1: the eighteen 16x16 products
  logic                s1_vld_q;
  logic signed [31:0]  s1_pa_q [Lanes];
  logic signed [31:0]  s1_pc_q [Lanes];
  logic signed [15:0]  s1_r0_q [3];

  // Stage 2: cofactors
  logic                s2_vld_q;
  logic signed [32:0]  s2_adj_q [Lanes];
  logic signed [15:0]  s2_r0_q [3];

  // Stage 3: first-row terms of the determinant
  logic                s3_vld_q;
  logic signed [32:0]  s3_adj_q [Lanes];
  logic signed [48:0]  s3_term_q [3];

  // Stage 4: determinant, magnitudes and signs
  logic                      s4_vld_q;
  mi3_pkg::mag_t [Lanes-1:0] s4_absn_q;
  mi3_pkg::den_t             s4_absd_q;
  mi3_pkg::div_tag_t         s4_tag_q;

  logic signed [50:0] det_d;
  logic signed [50:0] absdet_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start & ~busy;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_comb begin
    det_d    = 51'(s3_term_q[0]) + 51'(s3_term_q[1]) + 51'(s3_term_q[2]);
    absdet_d = det_d[50] ? -det_d : det_d;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Lanes; i++) begin
      s1_pa_q[i]  <= a[PA[i]] * a[PB[i]];
      s1_pc_q[i]  <= a[PC[i]] * a[PD[i]];
      s2_adj_q[i] <= 33'(s1_pa_q[i]) - 33'(s1_pc_q[i]);
      s3_adj_q[i] <= s2_adj_q[i];
    end
    for (int j = 0; j < 3; j++) begin
      s1_r0_q[j] <= a[j];
      s2_r0_q[j] <= s1_r0_q[j];
    end
    // det = a00*C00 + a01*C10 + a02*C20
    s3_term_q[0] <= 49'(s2_r0_q[0]) * 49'(s2_adj_q[0]);
    s3_term_q[1] <= 49'(s2_r0_q[1]) * 49'(s2_adj_q[3]);
    s3_term_q[2] <= 49'(s2_r0_q[2]) * 49'(s2_adj_q[6]);
    for (int i = 0; i < Lanes; i++) begin
      s4_absn_q[i]    <= s3_adj_q[i][32] ? 32'(-s3_adj_q[i]) : s3_adj_q[i][31:0];
      s4_tag_q.neg[i] <= s3_adj_q[i][32] ^ det_d[50];
    end
    s4_absd_q         <= absdet_d[mi3_pkg::DenW-1:0];
    s4_tag_q.singular <= det_d == '0;
  end

  logic                      dv_vld;
  mi3_pkg::quo_t [Lanes-1:0] dv_quo;
  logic [Lanes-1:0]          dv_ovf;
  mi3_pkg::div_tag_t         dv_tag;

  mi3_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s4_vld_q),
    .absn_i  (s4_absn_q),
    .absd_i  (s4_absd_q),
    .tag_i   (s4_tag_q),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .ovf_o   (dv_ovf),
    .tag_o   (dv_tag)
  );

  // Round half away from zero: quotient holds one extra fraction bit.
  logic [Lanes-1:0][33:0] qr;
  logic [Lanes-1:0][31:0] val_d;
  logic [Lanes-1:0]       sat_d;

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      qr[i] = 34'((35'(dv_quo[i]) + 35'd1) >> 1);
      if (dv_tag.neg[i]) begin
        sat_d[i] = dv_ovf[i] || (qr[i] > 34'h080000000);
        val_d[i] = sat_d[i] ? 32'h80000000 : 32'(-{1'b0, qr[i][31:0]});
      end else begin
        sat_d[i] = dv_ovf[i] || (qr[i] > 34'h07FFFFFFF);
        val_d[i] = sat_d[i] ? 32'h7FFFFFFF : qr[i][31:0];
      end
      if (dv_tag.singular) begin
        sat_d[i] = 1'b0;
        val_d[i] = '0;
      end
    end
  end

  logic          out_vld_q;
  mi3_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.inv_row0_col0 <= val_d[0];
    res_q.inv_row0_col1 <= val_d[1];
    res_q.inv_row0_col2 <= val_d[2];
    res_q.inv_row1_col0 <= val_d[3];
    res_q.inv_row1_col1 <= val_d[4];
    res_q.inv_row1_col2 <= val_d[5];
    res_q.inv_row2_col0 <= val_d[6];
    res_q.inv_row2_col1 <= val_d[7];
    res_q.inv_row2_col2 <= val_d[8];
    res_q.singular      <= dv_tag.singular;
    res_q.saturated     <= |sat_d;
  end

  assign done_o = out_vld_q;
  assign res_o  = res_q;

endmodule

[hdl/mi3_chk.sv]
// Port-level checker for matrix3x3_inverse, attached by bind.
// Depends on mi3_pkg and matrix3x3_inverse_macros.svh.
`include "matrix3x3_inverse_macros.svh"

module mi3_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input mi3_pkg::mat_t mat_i,
  input logic          done_o,
  input mi3_pkg::res_t res_o
);

  `MI3_ASSERT(a_never_busy, !busy, "busy raised")
  `MI3_ASSERT_IMP(a_done_after_start, start && !busy, ##(mi3_pkg::Latency) done_o, "result missing")
  `MI3_ASSERT_IMP(a_no_spurious_done, !start, ##(mi3_pkg::Latency) !done_o, "unexpected result")
  `MI3_ASSERT_IMP(a_singular_clean, done_o && res_o.singular, !res_o.saturated && res_o.inv_row0_col0 == 32'sd0 && res_o.inv_row2_col2 == 32'sd0, "singular result not zeroed")

endmodule

bind matrix3x3_inverse mi3_chk u_mi3_chk (.*);

[tb/tb_matrix3x3_inverse.sv]
// Testbench for matrix3x3_inverse: directed and random matrices, checked
// against an in-bench adjugate/determinant predictor. Depends on mi3_pkg.
`timescale 1ns / 100ps

module tb_matrix3x3_inverse;

  localparam int unsigned CycleLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  mi3_pkg::mat_t mat_i = '0;
  logic done_o;
  mi3_pkg::res_t res_o;

  matrix3x3_inverse dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .mat_i (mat_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  mi3_pkg::mat_t pending_mats[$];
  mi3_pkg::res_t expected_inv[$];
  int   mismatches = 0;
  int   idle_pct = 34;
  int   cycles = 0;

  // round(num/den), ties away from zero, clipped to 32 bits signed
  function automatic logic signed [31:0] div_round_clip(longint num, longint den,
                                                       ref logic clipped);
    logic neg;
    logic [63:0] an, ad, q, r;
    neg = (num < 0) != (den < 0);
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    q = an / ad;
    r = an % ad;
    if (r >= ad - r) q = q + 1;
    if (neg) begin
      if (q > 64'h8000_0000) begin
        clipped = 1'b1;
        return 32'sh8000_0000;
      end
      return -q[31:0];
    end
    if (q > 64'h7FFF_FFFF) begin
      clipped = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    return q[31:0];
  endfunction

  function automatic mi3_pkg::res_t invert_matrix(mi3_pkg::mat_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, det;
    longint adj[9];
    logic signed [31:0] v[9];
    logic clipped;
    mi3_pkg::res_t r;
    a00 = m.m_row0_col0; a01 = m.m_row0_col1; a02 = m.m_row0_col2;
    a10 = m.m_row1_col0; a11 = m.m_row1_col1; a12 = m.m_row1_col2;
    a20 = m.m_row2_col0; a21 = m.m_row2_col1; a22 = m.m_row2_col2;
    adj[0] = a11 * a22 - a21 * a12;
    adj[1] = a02 * a21 - a01 * a22;
    adj[2] = a01 * a12 - a02 * a11;
    adj[3] = a12 * a20 - a10 * a22;
    adj[4] = a00 * a22 - a02 * a20;
    adj[5] = a10 * a02 - a00 * a12;
    adj[6] = a10 * a21 - a20 * a11;
    adj[7] = a20 * a01 - a00 * a21;
    adj[8] = a00 * a11 - a10 * a01;
    det = a00 * adj[0] + a01 * adj[3] + a02 * adj[6];
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    clipped = 1'b0;
    for (int i = 0; i < 9; i++) v[i] = div_round_clip(adj[i] * (64'sd1 << 28), det, clipped);
    r.inv_row0_col0 = v[0]; r.inv_row0_col1 = v[1]; r.inv_row0_col2 = v[2];
    r.inv_row1_col0 = v[3]; r.inv_row1_col1 = v[4]; r.inv_row1_col2 = v[5];
    r.inv_row2_col0 = v[6]; r.inv_row2_col1 = v[7]; r.inv_row2_col2 = v[8];
    r.saturated = clipped;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // driver: start stays high across back-to-back transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_inv.push_back(invert_matrix(mat_i));
      end
      if (!(start && busy)) begin
        if (pending_mats.size() > 0 && $urandom_range(99) >= idle_pct) begin
          mat_i <= pending_mats.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    mi3_pkg::res_t want;
    if (rst_ni && done_o) begin
      if (expected_inv.size() == 0) begin
        report_mismatch("unexpected result", 32'd0, 32'd0);
      end else begin
        want = expected_inv.pop_front();
        if (res_o.inv_row0_col0 !== want.inv_row0_col0)
          report_mismatch("inv00", res_o.inv_row0_col0, want.inv_row0_col0);
        if (res_o.inv_row0_col1 !== want.inv_row0_col1)
          report_mismatch("inv01", res_o.inv_row0_col1, want.inv_row0_col1);
        if (res_o.inv_row0_col2 !== want.inv_row0_col2)
          report_mismatch("inv02", res_o.inv_row0_col2, want.inv_row0_col2);
        if (res_o.inv_row1_col0 !== want.inv_row1_col0)
          report_mismatch("inv10", res_o.inv_row1_col0, want.inv_row1_col0);
        if (res_o.inv_row1_col1 !== want.inv_row1_col1)
          report_mismatch("inv11", res_o.inv_row1_col1, want.inv_row1_col1);
        if (res_o.inv_row1_col2 !== want.inv_row1_col2)
          report_mismatch("inv12", res_o.inv_row1_col2, want.inv_row1_col2);
        if (res_o.inv_row2_col0 !== want.inv_row2_col0)
          report_mismatch("inv20", res_o.inv_row2_col0, want.inv_row2_col0);
        if (res_o.inv_row2_col1 !== want.inv_row2_col1)
          report_mismatch("inv21", res_o.inv_row2_col1, want.inv_row2_col1);
        if (res_o.inv_row2_col2 !== want.inv_row2_col2)
          report_mismatch("inv22", res_o.inv_row2_col2, want.inv_row2_col2);
        if (res_o.singular !== want.singular)
          report_mismatch("singular", 32'(res_o.singular), 32'(want.singular));
        if (res_o.saturated !== want.saturated)
          report_mismatch("saturated", 32'(res_o.saturated), 32'(want.saturated));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic mi3_pkg::mat_t diag_mat(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    mi3_pkg::mat_t m;
    m = '0;
    m.m_row0_col0 = a; m.m_row1_col1 = b; m.m_row2_col2 = c;
    return m;
  endfunction

  // random entry: full range, small values, or extremes
  function automatic logic [15:0] rand_entry();
    case ($urandom_range(3))
      0: return 16'($urandom_range(16'hFFFF));
      1: return 16'($signed($urandom_range(8192)) - 4096);
      2: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      default: return 16'($signed($urandom_range(600)) - 300);
    endcase
  endfunction

  function automatic mi3_pkg::mat_t rand_mat();
    mi3_pkg::mat_t m;
    logic [15:0] e[9];
    for (int i = 0; i < 9; i++) e[i] = rand_entry();
    m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    // some singular ones: repeat a row
    if ($urandom_range(15) == 0) m[47:0] = m[143:96];
    return m;
  endfunction

  task automatic drain();
    wait (pending_mats.size() == 0 && !start);
    wait (expected_inv.size() == 0);
  endtask

  initial begin
    mi3_pkg::mat_t m;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed
    pending_mats.push_back(diag_mat(16'h1000, 16'h1000, 16'h1000)); // identity
    pending_mats.push_back('0);                                      // zero: singular
    pending_mats.push_back(diag_mat(16'h0001, 16'h0001, 16'h0001)); // tiny: unit diagonal
    pending_mats.push_back(diag_mat(16'h8000, 16'h8000, 16'h8000));
    pending_mats.push_back(diag_mat(16'h7FFF, 16'h7FFF, 16'h7FFF));
    pending_mats.push_back(diag_mat(16'h8000, 16'h7FFF, 16'hFFFF));
    pending_mats.push_back(diag_mat(16'h2000, 16'hE000, 16'h0800));
    pending_mats.push_back(diag_mat(16'h0003, 16'h1000, 16'h1000)); // rounding of inexact quotients
    pending_mats.push_back('1);                                      // all -1 lsb: singular
    pending_mats.push_back({9{16'h8000}});
    pending_mats.push_back({9{16'h7FFF}});
    m = {16'h1000, 16'h2000, 16'h3000, 16'h0000, 16'h1000, 16'h4000,
         16'h5000, 16'h6000, 16'h0000};
    pending_mats.push_back(m);
    m = {16'h0000, 16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h1000,
         16'h1000, 16'h0000, 16'h0000};                              // permutation
    pending_mats.push_back(m);
    m = {16'h7FFF, 16'h8000, 16'h0001, 16'h8000, 16'h7FFF, 16'hFFFF,
         16'h0001, 16'hFFFF, 16'h7FFF};
    pending_mats.push_back(m);
    pending_mats.push_back(diag_mat(16'h0003, 16'h0003, 16'h0003));
    drain();
    // hold off until all results are back, then random phases
    idle_pct = 34;
    for (int i = 0; i < 180; i++) pending_mats.push_back(rand_mat());
    drain();
    idle_pct = 68;
    for (int i = 0; i < 180; i++) pending_mats.push_back(rand_mat());
    drain();
    idle_pct = 0;
    for (int i = 0; i < 180; i++) pending_mats.push_back(rand_mat());
    drain();
    repeat (mi3_pkg::Latency + 10) @(posedge clk_i);
    if (mismatches == 0 && expected_inv.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[matrix3x3_inverse.f]
+incdir+hdl
hdl/mi3_pkg.sv
hdl/mi3_div.sv
hdl/matrix3x3_inverse.sv
hdl/mi3_chk.sv
tb/tb_matrix3x3_inverse.sv
